### hdl/shabh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte hasher.
package shabh_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CHAIN_N  = 8;
    localparam int unsigned BLK_WRDS = 16;
    localparam int unsigned ROUNDS   = 64;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_ERD,
        S_EOUT,
        S_EWAIT
    } t_state;

    // Control from the sequencer to the compression datapath.
    typedef struct packed {
        logic       w_load;
        logic       v_load;
        logic       round;
        logic       v_shift;
        logic [5:0] rnd;
    } t_comp_ctrl;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] a);
        big_s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] e);
        big_s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        sml_s0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] y);
        sml_s1 = ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10);
    endfunction

    function automatic logic [31:0] shabh_iv(input logic [2:0] idx);
        unique case (idx)
            3'd0: shabh_iv = 32'h6a09e667;
            3'd1: shabh_iv = 32'hbb67ae85;
            3'd2: shabh_iv = 32'h3c6ef372;
            3'd3: shabh_iv = 32'ha54ff53a;
            3'd4: shabh_iv = 32'h510e527f;
            3'd5: shabh_iv = 32'h9b05688c;
            3'd6: shabh_iv = 32'h1f83d9ab;
            3'd7: shabh_iv = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] shabh_k(input logic [5:0] idx);
        unique case (idx)
            6'd0:  shabh_k = 32'h428a2f98;  6'd1:  shabh_k = 32'h71374491;
            6'd2:  shabh_k = 32'hb5c0fbcf;  6'd3:  shabh_k = 32'he9b5dba5;
            6'd4:  shabh_k = 32'h3956c25b;  6'd5:  shabh_k = 32'h59f111f1;
            6'd6:  shabh_k = 32'h923f82a4;  6'd7:  shabh_k = 32'hab1c5ed5;
            6'd8:  shabh_k = 32'hd807aa98;  6'd9:  shabh_k = 32'h12835b01;
            6'd10: shabh_k = 32'h243185be;  6'd11: shabh_k = 32'h550c7dc3;
            6'd12: shabh_k = 32'h72be5d74;  6'd13: shabh_k = 32'h80deb1fe;
            6'd14: shabh_k = 32'h9bdc06a7;  6'd15: shabh_k = 32'hc19bf174;
            6'd16: shabh_k = 32'he49b69c1;  6'd17: shabh_k = 32'hefbe4786;
            6'd18: shabh_k = 32'h0fc19dc6;  6'd19: shabh_k = 32'h240ca1cc;
            6'd20: shabh_k = 32'h2de92c6f;  6'd21: shabh_k = 32'h4a7484aa;
            6'd22: shabh_k = 32'h5cb0a9dc;  6'd23: shabh_k = 32'h76f988da;
            6'd24: shabh_k = 32'h983e5152;  6'd25: shabh_k = 32'ha831c66d;
            6'd26: shabh_k = 32'hb00327c8;  6'd27: shabh_k = 32'hbf597fc7;
            6'd28: shabh_k = 32'hc6e00bf3;  6'd29: shabh_k = 32'hd5a79147;
            6'd30: shabh_k = 32'h06ca6351;  6'd31: shabh_k = 32'h14292967;
            6'd32: shabh_k = 32'h27b70a85;  6'd33: shabh_k = 32'h2e1b2138;
            6'd34: shabh_k = 32'h4d2c6dfc;  6'd35: shabh_k = 32'h53380d13;
            6'd36: shabh_k = 32'h650a7354;  6'd37: shabh_k = 32'h766a0abb;
            6'd38: shabh_k = 32'h81c2c92e;  6'd39: shabh_k = 32'h92722c85;
            6'd40: shabh_k = 32'ha2bfe8a1;  6'd41: shabh_k = 32'ha81a664b;
            6'd42: shabh_k = 32'hc24b8b70;  6'd43: shabh_k = 32'hc76c51a3;
            6'd44: shabh_k = 32'hd192e819;  6'd45: shabh_k = 32'hd6990624;
            6'd46: shabh_k = 32'hf40e3585;  6'd47: shabh_k = 32'h106aa070;
            6'd48: shabh_k = 32'h19a4c116;  6'd49: shabh_k = 32'h1e376c08;
            6'd50: shabh_k = 32'h2748774c;  6'd51: shabh_k = 32'h34b0bcb5;
            6'd52: shabh_k = 32'h391c0cb3;  6'd53: shabh_k = 32'h4ed8aa4a;
            6'd54: shabh_k = 32'h5b9cca4f;  6'd55: shabh_k = 32'h682e6ff3;
            6'd56: shabh_k = 32'h748f82ee;  6'd57: shabh_k = 32'h78a5636f;
            6'd58: shabh_k = 32'h84c87814;  6'd59: shabh_k = 32'h8cc70208;
            6'd60: shabh_k = 32'h90befffa;  6'd61: shabh_k = 32'ha4506ceb;
            6'd62: shabh_k = 32'hbef9a3f7;  6'd63: shabh_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

### hdl/shabh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shabh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/shabh_comp.sv
// Compression datapath: schedule window and working variables, one round a cycle.
module shabh_comp (
    input  logic                    i_clk,
    input  shabh_pkg::t_comp_ctrl   i_ctrl,
    input  logic [31:0]             i_blk_q,
    input  logic [31:0]             i_chain_q,
    output logic [31:0]             o_v0
);
    import shabh_pkg::*;

    logic [31:0] r_w [BLK_WRDS];
    logic [31:0] r_v [CHAIN_N];
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        w_next = sml_s1(r_w[14]) + r_w[9] + sml_s0(r_w[1]) + r_w[0];
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + shabh_k(i_ctrl.rnd) + r_w[0];
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.w_load || i_ctrl.round) begin
            for (int i = 0; i < BLK_WRDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLK_WRDS-1] <= i_ctrl.round ? w_next : i_blk_q;
        end
        if (i_ctrl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (i_ctrl.v_load || i_ctrl.v_shift) begin
            // Shift toward word 0; loading fills from the top with chain data.
            for (int i = 0; i < CHAIN_N - 1; i++) begin
                r_v[i] <= r_v[i+1];
            end
            r_v[CHAIN_N-1] <= i_chain_q;
        end
    end

    assign o_v0 = r_v[0];

endmodule

### hdl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte-stream hasher top: byte intake, padding, sequencer, digest output.
// Absorb request: the 64th byte of a block starts a compression (load from block/chain
// RAM, 64 rounds, fold-back) before the next request.
// Finish request: pad to the block end at one byte per cycle (up to 63), compress; when the
// length does not fit, pad 64 more bytes and compress again; digest words wait for ready.
// Reset clears control, fill count and bit length; chain words read as the initial values.
module sha256_byte_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_axis_tlast
);
    import shabh_pkg::*;

    t_state       r_state;
    t_state       n_state;
    logic [5:0]   r_cnt;
    logic [5:0]   r_fill;
    logic [63:0]  r_bitlen;
    logic [23:0]  r_word;
    logic         r_fin;
    logic         r_len_ok;
    logic         r_last_blk;
    logic [2:0]   r_idx;
    logic [7:0]   r_chain_vld;
    logic         r_rd_sel;
    logic [2:0]   r_rd_addr;
    logic         r_out_vld;
    logic [31:0]  r_out_word;
    logic [2:0]   r_out_idx;

    t_comp_ctrl   comp_ctrl;
    logic         in_acc;
    logic         append;
    logic [7:0]   app_byte;
    logic [7:0]   len_byte;
    logic         blk_we;
    logic [31:0]  blk_q;
    logic         chain_we;
    logic [2:0]   chain_waddr;
    logic [31:0]  chain_wdata;
    logic [2:0]   chain_raddr;
    logic [31:0]  chain_ram_q;
    logic [31:0]  chain_q;
    logic [31:0]  v0;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign len_byte = r_bitlen[{~r_fill[2:0], 3'b000} +: 8];
    assign chain_q  = r_rd_sel ? chain_ram_q : shabh_iv(r_rd_addr);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_fill == 6'd63) begin
                        n_state = S_LOAD;
                    end else if (s_axis_tuser == KIND_FINISH) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_fill == 6'd63) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_cnt == 6'd16) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_cnt == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_cnt == 6'd8) begin
                    priority if (!r_fin) begin
                        n_state = S_IDLE;
                    end else if (r_last_blk) begin
                        n_state = S_ERD;
                    end else begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ERD:  n_state = S_EOUT;
            S_EOUT: n_state = S_EWAIT;
            S_EWAIT: begin
                if (m_axis_tready) begin
                    n_state = (r_idx == 3'd7) ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        append        = 1'b0;
        app_byte      = 8'h00;
        comp_ctrl     = '0;
        comp_ctrl.rnd = r_cnt;
        chain_we      = 1'b0;
        chain_waddr   = 3'(r_cnt - 6'd1);
        chain_wdata   = chain_q + v0;
        chain_raddr   = r_cnt[2:0];
        unique case (r_state)
            S_IDLE: begin
                append   = in_acc;
                app_byte = (s_axis_tuser == KIND_FINISH) ? PAD_MARK : s_axis_tdata;
            end
            S_PAD: begin
                append   = 1'b1;
                app_byte = (r_len_ok && r_fill[5:3] == 3'b111) ? len_byte : 8'h00;
            end
            S_LOAD: begin
                comp_ctrl.w_load = (r_cnt != 6'd0);
                comp_ctrl.v_load = (r_cnt != 6'd0) && (r_cnt <= 6'd8);
            end
            S_ROUND: comp_ctrl.round = 1'b1;
            S_FOLD: begin
                comp_ctrl.v_shift = (r_cnt != 6'd0);
                chain_we          = (r_cnt != 6'd0);
            end
            S_ERD:   chain_raddr = r_idx;
            S_EOUT:  ;
            S_EWAIT: ;
            default: ;
        endcase
        blk_we = append && (r_fill[1:0] == 2'b11);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_fin       <= 1'b0;
            r_len_ok    <= 1'b0;
            r_last_blk  <= 1'b0;
            r_idx       <= '0;
            r_chain_vld <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (append) begin
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == S_IDLE && in_acc) begin
                if (s_axis_tuser == KIND_FINISH) begin
                    r_fin    <= 1'b1;
                    r_len_ok <= (r_fill <= 6'd55);
                end else begin
                    r_bitlen <= r_bitlen + 64'd8;
                end
                r_last_blk <= 1'b0;
            end
            if (r_state == S_PAD && r_fill == 6'd63) begin
                r_last_blk <= r_len_ok;
            end
            // Advance the phase counter; restart it on every state change.
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state == S_LOAD || r_state == S_ROUND || r_state == S_FOLD) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (chain_we) begin
                r_chain_vld[chain_waddr] <= 1'b1;
            end
            if (r_state == S_FOLD && r_cnt == 6'd8 && r_fin) begin
                if (r_last_blk) begin
                    r_fin    <= 1'b0;
                    r_bitlen <= '0;
                    r_idx    <= '0;
                end else begin
                    r_len_ok <= 1'b1;
                end
            end
            // Drop the chain word once read out: it reads as the initial value again.
            if (r_state == S_ERD) begin
                r_chain_vld[r_idx] <= 1'b0;
            end
            if (r_state == S_EOUT) begin
                r_out_vld <= 1'b1;
            end
            if (r_state == S_EWAIT && m_axis_tready) begin
                r_out_vld <= 1'b0;
                r_idx     <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (append) begin
            r_word <= {r_word[15:0], app_byte};
        end
        r_rd_sel  <= r_chain_vld[chain_raddr];
        r_rd_addr <= chain_raddr;
        if (r_state == S_EOUT) begin
            r_out_word <= chain_q;
            r_out_idx  <= r_idx;
        end
    end

    shabh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (r_fill[5:2]),
        .i_wdata ({r_word, app_byte}),
        .i_raddr (r_cnt[3:0]),
        .o_rdata (blk_q)
    );

    shabh_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_waddr (chain_waddr),
        .i_wdata (chain_wdata),
        .i_raddr (chain_raddr),
        .o_rdata (chain_ram_q)
    );

    shabh_comp u_comp (
        .i_clk     (i_clk),
        .i_ctrl    (comp_ctrl),
        .i_blk_q   (blk_q),
        .i_chain_q (chain_q),
        .o_v0      (v0)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_idx, r_out_word};
    assign m_axis_tlast  = (r_out_idx == 3'd7);

    a_round_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_fill == 6'd0))
        else $error("compression running on a partly filled block");

    a_emit_chain_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD && r_idx == 3'd0) |-> (r_chain_vld == 8'hff))
        else $error("digest read before all chain words were folded");

    a_no_intake_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !s_axis_tready)
        else $error("request taken while a digest word is pending");

    a_restart_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (r_chain_vld == 8'h00 && r_bitlen == 64'd0 && r_fill == 6'd0))
        else $error("hash state not restarted after the last digest word");

endmodule
